>>> hdl/rap_pkg.sv
// Shared types and constants for the rolling autoscale plot block.
package rap_pkg;

	localparam int SAMPLE_W = 24;
	localparam int IDX_W    = 9;
	localparam int PIX_W    = 8;
	localparam int DIV_W    = 32;
	localparam int CFG_IDX_W = 1;

	localparam logic [SAMPLE_W-1:0] MIN_START  = 24'd10000000;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 24'd9999999;
	localparam logic [PIX_W-1:0]    WIDTH_RESET  = 8'd128;
	localparam logic [PIX_W-1:0]    HEIGHT_RESET = 8'd32;

	// action codes
	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_READ = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PLOT_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PLOT_HEIGHT = 1'b1;

	// divider request and response
	typedef struct packed {
		logic                start;
		logic [DIV_W-1:0]    dividend;
		logic [SAMPLE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

>>> hdl/rap_cell.sv
// One storage cell of the sample chain: takes its neighbor's value on a shift.
module rap_cell import rap_pkg::*; (
	input  logic                clk,
	input  logic                shift,
	input  logic [SAMPLE_W-1:0] din,
	output logic [SAMPLE_W-1:0] dout
);

	logic [SAMPLE_W-1:0] val_q;

	// hold or take the neighbor's sample
	always_ff @(posedge clk) begin
		if (shift) begin
			val_q <= din;
		end
	end

	assign dout = val_q;

endmodule

>>> hdl/rap_div.sv
// Restoring divider, one quotient bit per cycle.
module rap_div import rap_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIV_W);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [SAMPLE_W-1:0] rem_q;
	logic [SAMPLE_W-1:0] dsr_q;
	logic [DIV_W-1:0]    quo_q;

	logic [SAMPLE_W:0]   trial;
	logic                ge;
	logic [SAMPLE_W:0]   diff;

	// trial subtract of the next dividend bit
	always_comb begin
		trial = {rem_q, quo_q[DIV_W-1]};
		diff  = trial - {1'b0, dsr_q};
		ge    = (trial >= {1'b0, dsr_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

>>> hdl/rolling_autoscale_plot_top.sv
// Rolling autoscale plot: sample window as a rotating chain of cells, min/max rescan, scaling.
// A push rotates the whole chain (after a drop step if the window is full), then finishes;
//   a stored point read scans, scales and divides; a read past the fill count ends next cycle.
// Throughput: one item at a time, held busy by the chain rotation and, for a read, the divide.
// Results are strobed by done for one cycle; the receiver cannot stall.
// Reset (arst_n low) empties the window: min 10000000, max 0, width 128, height 32.
// No clearing pass: cells past the fill count are never read.
module rolling_autoscale_plot_top import rap_pkg::*; #(
	parameter int DEPTH = 512
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 action,
	input  logic [SAMPLE_W-1:0]  sample,
	input  logic [IDX_W-1:0]     point_index,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PIX_W-1:0]     cfg_data,
	output logic                 done,
	output logic [SAMPLE_W-1:0]  window_min,
	output logic [SAMPLE_W-1:0]  window_max,
	output logic [SAMPLE_W-1:0]  span,
	output logic [PIX_W-1:0]     point_x,
	output logic [PIX_W-1:0]     point_y,
	output logic                 point_valid
);

	localparam int FILL_W = $clog2(DEPTH + 1);
	localparam int CMP_W  = (FILL_W > IDX_W) ? FILL_W : IDX_W;

	// x scaling by DEPTH as a reciprocal multiply, exact for every index times width
	localparam int XPROD_W = IDX_W + PIX_W;
	localparam int X_SHIFT = XPROD_W + $clog2(DEPTH);
	localparam int RECIP_W = XPROD_W + 2;
	localparam int XMUL_W  = XPROD_W + RECIP_W;
	localparam logic [RECIP_W-1:0] X_RECIP =
		RECIP_W'(((64'd1 << X_SHIFT) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DROP,
		ST_SCAN,
		ST_SCALE,
		ST_DIVY,
		ST_WAITY
	} state_t;

	state_t              state_q;
	logic                done_q;
	logic [FILL_W-1:0]   fill_q;
	logic [FILL_W-1:0]   k_q;
	logic                push_q;
	logic                full_q;
	logic [SAMPLE_W-1:0] samp_q;
	logic [IDX_W-1:0]    idx_q;
	logic [SAMPLE_W-1:0] lo_q;
	logic [SAMPLE_W-1:0] hi_q;
	logic [SAMPLE_W-1:0] v_q;
	logic [SAMPLE_W-1:0] held_min_q;
	logic [SAMPLE_W-1:0] held_max_q;
	logic [PIX_W-1:0]    width_q;
	logic [PIX_W-1:0]    height_q;
	logic [PIX_W-1:0]    px_q;
	logic [PIX_W-1:0]    py_q;
	logic                pv_q;
	logic [DIV_W-1:0]    prod_s1;

	logic [SAMPLE_W-1:0] cell_d [DEPTH];
	logic [SAMPLE_W-1:0] head;
	logic [SAMPLE_W-1:0] feed;
	logic                shift_en;
	logic                insert;
	logic                take_in;
	logic [SAMPLE_W-1:0] lo_nxt;
	logic [SAMPLE_W-1:0] hi_nxt;
	logic [SAMPLE_W-1:0] samp_sat;
	logic [SAMPLE_W-1:0] span_v;
	logic [SAMPLE_W-1:0] off;
	logic [XPROD_W-1:0]  xprod;
	logic [XMUL_W-1:0]   xmul;
	logic [SAMPLE_W+PIX_W-1:0] yprod;
	logic                idx_ok;
	logic                idx_hit;
	div_req_t            div_req;
	div_rsp_t            div_rsp;

	// sample chain: cell i takes cell i+1, the last cell takes the feed
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [SAMPLE_W-1:0] din_w;
		if (i == DEPTH - 1) begin : g_last
			assign din_w = feed;
		end else begin : g_mid
			assign din_w = cell_d[i+1];
		end
		rap_cell u_cell (
			.clk   (clk),
			.shift (shift_en),
			.din   (din_w),
			.dout  (cell_d[i])
		);
	end

	assign head = cell_d[0];

	// chain control and running min/max on the value entering the tail
	always_comb begin
		shift_en = (state_q == ST_DROP) || (state_q == ST_SCAN);
		insert   = push_q && !full_q && (k_q == fill_q);
		take_in  = push_q && (k_q <= fill_q);
		if (state_q == ST_DROP || insert) begin
			feed = samp_q;
		end else begin
			feed = head;
		end
		lo_nxt = (take_in && feed < lo_q) ? feed : lo_q;
		hi_nxt = (take_in && feed > hi_q) ? feed : hi_q;
	end

	// input saturation and index checks
	always_comb begin
		samp_sat = (sample > SAMPLE_MAX) ? SAMPLE_MAX : sample;
		idx_ok   = CMP_W'(point_index) < CMP_W'(fill_q);
		idx_hit  = CMP_W'(k_q) == CMP_W'(idx_q);
	end

	// span of the held window; empty window gives one
	assign span_v = (held_max_q < held_min_q) ? SAMPLE_W'(1) : held_max_q - held_min_q + 1'b1;

	// scaling products
	always_comb begin
		off   = (v_q >= held_min_q) ? v_q - held_min_q : '0;
		xprod = idx_q * width_q;
		xmul  = XMUL_W'(xprod) * XMUL_W'(X_RECIP);
		yprod = off * height_q;
	end

	// divider request: y product by span
	always_comb begin
		div_req.start    = (state_q == ST_DIVY);
		div_req.dividend = prod_s1;
		div_req.divisor  = span_v;
	end

	rap_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PLOT_WIDTH:  width_q  <= cfg_data;
				CFG_PLOT_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer with held state and registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			done_q     <= 1'b0;
			fill_q     <= '0;
			held_min_q <= MIN_START;
			held_max_q <= '0;
			k_q        <= '0;
			push_q     <= 1'b0;
			full_q     <= 1'b0;
			px_q       <= '0;
			py_q       <= '0;
			pv_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						push_q <= (action == ACT_PUSH);
						samp_q <= samp_sat;
						idx_q  <= point_index;
						k_q    <= '0;
						lo_q   <= MIN_START;
						hi_q   <= '0;
						full_q <= (fill_q == FILL_W'(DEPTH));
						if (action == ACT_PUSH) begin
							state_q <= (fill_q == FILL_W'(DEPTH)) ? ST_DROP : ST_SCAN;
						end else if (idx_ok) begin
							state_q <= ST_SCAN;
						end else begin
							px_q   <= '0;
							py_q   <= '0;
							pv_q   <= 1'b0;
							done_q <= 1'b1;
						end
					end
				end
				ST_DROP: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					k_q  <= k_q + 1'b1;
					lo_q <= lo_nxt;
					hi_q <= hi_nxt;
					if (!push_q && idx_hit) begin
						v_q <= head;
					end
					if (k_q == FILL_W'(DEPTH - 1)) begin
						if (push_q) begin
							held_min_q <= lo_nxt;
							held_max_q <= hi_nxt;
							if (!full_q) begin
								fill_q <= fill_q + 1'b1;
							end
							px_q    <= '0;
							py_q    <= '0;
							pv_q    <= 1'b0;
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_SCALE;
						end
					end
				end
				ST_SCALE: begin
					px_q    <= PIX_W'(xmul >> X_SHIFT);
					prod_s1 <= DIV_W'(yprod);
					state_q <= ST_DIVY;
				end
				ST_DIVY: begin
					state_q <= ST_WAITY;
				end
				ST_WAITY: begin
					if (div_rsp.done) begin
						if (height_q == '0 || div_rsp.quotient >= DIV_W'(height_q)) begin
							py_q <= '0;
						end else begin
							py_q <= height_q - 1'b1 - div_rsp.quotient[PIX_W-1:0];
						end
						pv_q    <= 1'b1;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign window_min  = held_min_q;
	assign window_max  = held_max_q;
	assign span        = span_v;
	assign point_x     = px_q;
	assign point_y     = py_q;
	assign point_valid = pv_q;

	// fill count never passes the window depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(DEPTH))
		else $error("fill count beyond window depth");

	// an accepted item makes the block busy unless it finishes at once
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted item neither busy nor done");

	// a push result never carries a valid point
	a_push_no_point: assert property (@(posedge clk) disable iff (!arst_n)
		(done && push_q) |-> !point_valid)
		else $error("push result flagged a valid point");

	// the divider only answers while a read waits for it
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_WAITY))
		else $error("divider result with no waiting read");

endmodule

>>> tb/sv/rap_plot_checker.sv
// Checker for the rolling autoscale plot: predicts each result beat and compares it.
`timescale 1ns / 100ps

module rap_plot_checker import rap_pkg::*; #(
	parameter int DEPTH = 512
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic                 action,
	input  logic [SAMPLE_W-1:0]  sample,
	input  logic [IDX_W-1:0]     point_index,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PIX_W-1:0]     cfg_data,
	input  logic                 done,
	input  logic [SAMPLE_W-1:0]  window_min,
	input  logic [SAMPLE_W-1:0]  window_max,
	input  logic [SAMPLE_W-1:0]  span,
	input  logic [PIX_W-1:0]     point_x,
	input  logic [PIX_W-1:0]     point_y,
	input  logic                 point_valid,
	output int                   fail_count,
	output int                   pending
);

	typedef struct packed {
		logic [SAMPLE_W-1:0] lo;
		logic [SAMPLE_W-1:0] hi;
		logic [SAMPLE_W-1:0] range;
		logic [PIX_W-1:0]    px;
		logic [PIX_W-1:0]    py;
		logic                valid;
	} chart_beat_t;

	// shadow of the window and of the chart registers
	logic [SAMPLE_W-1:0] win_samples [DEPTH];
	int unsigned         win_fill;
	logic [SAMPLE_W-1:0] lo_held;
	logic [SAMPLE_W-1:0] hi_held;
	logic [PIX_W-1:0]    width_reg;
	logic [PIX_W-1:0]    height_reg;
	chart_beat_t         chart_beats[$];
	int                  fails;

	// apply one command to the shadow window and work out its beat
	task automatic take_command(input logic act, input logic [SAMPLE_W-1:0] smp,
		input logic [IDX_W-1:0] idx, output chart_beat_t beat);
		logic [SAMPLE_W-1:0] v;
		logic [SAMPLE_W-1:0] lo;
		logic [SAMPLE_W-1:0] hi;
		logic [SAMPLE_W-1:0] sp;
		longint unsigned     off;
		longint unsigned     q;
		beat = '0;
		if (act == ACT_PUSH) begin
			v = (smp > SAMPLE_MAX) ? SAMPLE_MAX : smp;
			if (win_fill < DEPTH) begin
				win_samples[win_fill] = v;
				win_fill++;
			end else begin
				// full window: oldest sample falls out
				for (int i = 0; i < DEPTH - 1; i++)
					win_samples[i] = win_samples[i+1];
				win_samples[DEPTH-1] = v;
			end
			lo = MIN_START;
			hi = '0;
			for (int i = 0; i < win_fill; i++) begin
				if (win_samples[i] > hi)
					hi = win_samples[i];
				if (win_samples[i] < lo)
					lo = win_samples[i];
			end
			lo_held = lo;
			hi_held = hi;
		end
		// empty window has max below min
		sp = (hi_held < lo_held) ? SAMPLE_W'(1) : hi_held - lo_held + SAMPLE_W'(1);
		beat.lo    = lo_held;
		beat.hi    = hi_held;
		beat.range = sp;
		if (act == ACT_READ && idx < win_fill && idx < DEPTH) begin
			beat.valid = 1'b1;
			beat.px = PIX_W'((int'(idx) * int'(width_reg)) / DEPTH);
			v = win_samples[idx];
			off = (v >= lo_held) ? longint'(v - lo_held) : 0;
			q = (off * height_reg) / sp;
			if (height_reg == 0 || q + 1 > height_reg)
				beat.py = '0;
			else
				beat.py = PIX_W'(height_reg - 1 - q);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		chart_beat_t want;
		chart_beat_t got;
		if (!arst_n) begin
			win_fill   = 0;
			lo_held    = MIN_START;
			hi_held    = '0;
			width_reg  = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			chart_beats.delete();
			fails = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			// result side first: a beat never finishes on its own accept edge
			if (done) begin
				got = '{window_min, window_max, span, point_x, point_y, point_valid};
				if (chart_beats.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected result beat: min %0d max %0d span %0d x %0d y %0d v %0d",
							got.lo, got.hi, got.range, got.px, got.py, got.valid);
				end else begin
					want = chart_beats.pop_front();
					if (got !== want) begin
						fails++;
						if (fails <= 10) begin
							$display("result mismatch at %0t", $realtime);
							$display("  exp min %0d max %0d span %0d x %0d y %0d v %0d",
								want.lo, want.hi, want.range, want.px, want.py, want.valid);
							$display("  got min %0d max %0d span %0d x %0d y %0d v %0d",
								got.lo, got.hi, got.range, got.px, got.py, got.valid);
						end
					end
				end
			end
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					CFG_PLOT_WIDTH: begin
						width_reg = cfg_data;
					end
					CFG_PLOT_HEIGHT: begin
						height_reg = cfg_data;
					end
					default: ;
				endcase
			end
			// accepted command beat
			if (start && !busy) begin
				take_command(action, sample, point_index, want);
				chart_beats.push_back(want);
			end
			fail_count <= fails;
			pending    <= chart_beats.size();
		end
	end

endmodule

>>> tb/sv/tb_rolling_autoscale_plot_top.sv
// Testbench top for the rolling autoscale plot: stimulus, register writes and verdict.
`timescale 1ns / 100ps

module tb_rolling_autoscale_plot_top;
	import rap_pkg::*;

	localparam int DEPTH = 512;
	localparam int PHASE_ITEMS = 384;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic                 action = ACT_PUSH;
	logic [SAMPLE_W-1:0]  sample = '0;
	logic [IDX_W-1:0]     point_index = '0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_PLOT_WIDTH;
	logic [PIX_W-1:0]     cfg_data = '0;
	logic                 done;
	logic [SAMPLE_W-1:0]  window_min;
	logic [SAMPLE_W-1:0]  window_max;
	logic [SAMPLE_W-1:0]  span;
	logic [PIX_W-1:0]     point_x;
	logic [PIX_W-1:0]     point_y;
	logic                 point_valid;
	int                   fail_count;
	int                   pending;

	int                   sender_idle = 0;
	int                   pushes_sent = 0;
	logic [SAMPLE_W-1:0]  cluster_base = 24'd500000;

	always #2 clk = ~clk;

	rolling_autoscale_plot_top #(.DEPTH(DEPTH)) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.sample     (sample),
		.point_index(point_index),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.done       (done),
		.window_min (window_min),
		.window_max (window_max),
		.span       (span),
		.point_x    (point_x),
		.point_y    (point_y),
		.point_valid(point_valid)
	);

	rap_plot_checker #(.DEPTH(DEPTH)) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.sample     (sample),
		.point_index(point_index),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.done       (done),
		.window_min (window_min),
		.window_max (window_max),
		.span       (span),
		.point_x    (point_x),
		.point_y    (point_y),
		.point_valid(point_valid),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// one command beat; returns right after the accepting edge with start still high
	task automatic send_cmd(input logic act, input logic [SAMPLE_W-1:0] smp,
		input logic [IDX_W-1:0] idx);
		int gap;
		gap = 0;
		while ($urandom_range(99) < sender_idle)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		action      <= act;
		sample      <= smp;
		point_index <= idx;
		if (act == ACT_PUSH)
			pushes_sent++;
		do
			@(posedge clk);
		while (busy);
	endtask

	// hold off until every outstanding result beat has come back
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write both chart registers back to back
	task automatic write_plot(input logic [PIX_W-1:0] w, input logic [PIX_W-1:0] h);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_PLOT_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= CFG_PLOT_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// random register value, zero now and then
	function automatic logic [PIX_W-1:0] rand_reg();
		if ($urandom_range(7) == 0)
			return '0;
		return PIX_W'($urandom_range(255));
	endfunction

	// one random command: mostly clustered pushes and reads of stored points
	task automatic random_cmd();
		logic [SAMPLE_W-1:0] smp;
		logic [IDX_W-1:0]    idx;
		int                  fill;
		int                  push_pct;
		fill = (pushes_sent > DEPTH) ? DEPTH : pushes_sent;
		push_pct = (pushes_sent < DEPTH + 80) ? 65 : 40;
		if ($urandom_range(39) == 0)
			cluster_base = SAMPLE_W'($urandom_range(9990000));
		smp = '0;
		idx = '0;
		if ($urandom_range(99) < push_pct) begin
			case ($urandom_range(9))
				0: smp = SAMPLE_W'($urandom);
				1: smp = $urandom_range(1) ? SAMPLE_MAX : '0;
				2: smp = cluster_base + SAMPLE_W'($urandom_range(7));
				default: smp = cluster_base + SAMPLE_W'($urandom_range(5000));
			endcase
			send_cmd(ACT_PUSH, smp, IDX_W'($urandom));
		end else begin
			if (fill > 0 && $urandom_range(3) != 0)
				idx = IDX_W'($urandom_range(fill - 1));
			else
				idx = IDX_W'($urandom_range(DEPTH - 1));
			send_cmd(ACT_READ, SAMPLE_W'($urandom), idx);
		end
	endtask

	// overall run limit
	initial begin
		#20_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// empty window reads, then saturation and scaling at reset sizes
		send_cmd(ACT_READ, '0, '0);
		send_cmd(ACT_READ, '1, '1);
		send_cmd(ACT_PUSH, '0, '0);
		send_cmd(ACT_READ, '0, '0);
		send_cmd(ACT_PUSH, 24'hFFFFFF, '0);
		send_cmd(ACT_PUSH, MIN_START, '0);
		send_cmd(ACT_PUSH, SAMPLE_MAX, '0);
		send_cmd(ACT_PUSH, 24'd4999999, '0);
		for (int i = 0; i < 5; i++)
			send_cmd(ACT_READ, '0, IDX_W'(i));
		send_cmd(ACT_READ, '0, IDX_W'(5));
		send_cmd(ACT_READ, '0, '1);

		// zero sized chart
		settle();
		write_plot('0, '0);
		send_cmd(ACT_READ, '0, IDX_W'(1));
		send_cmd(ACT_READ, '0, IDX_W'(3));

		// largest chart
		settle();
		write_plot('1, '1);
		send_cmd(ACT_READ, '0, '0);
		send_cmd(ACT_READ, '0, IDX_W'(3));
		send_cmd(ACT_PUSH, 24'd1, '0);
		send_cmd(ACT_READ, '0, IDX_W'(4));
		send_cmd(ACT_READ, '0, IDX_W'(5));

		// random phases with changing idle rates and chart sizes
		for (int phase = 0; phase < 3; phase++) begin
			settle();
			case (phase)
				0: begin
					sender_idle = 35;
					write_plot('1, '1);
				end
				1: begin
					sender_idle = 61;
					write_plot(8'd1, 8'd1);
				end
				default: begin
					sender_idle = 0;
					write_plot(rand_reg(), rand_reg());
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 128 == 127) begin
					settle();
					write_plot(rand_reg(), rand_reg());
				end
				random_cmd();
			end
		end

		settle();
		repeat (DEPTH + 80) @(posedge clk);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
